// ----- rtl/vdp_pkg.sv -----
// Shared types, constants and helpers for the Van der Pol RK4 stepper.
`timescale 1ns / 1ps

package vdp_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int STEP_BITS_DEF = 20;

  localparam int WORD_W     = 32;  // state and slope words
  localparam int IDX_W      = 20;  // reported step index
  localparam int MU_W       = 31;  // mu and 1/mu registers
  localparam int DT_W       = 25;  // time step register
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OPND_W     = 34;  // multiplier operand
  localparam int PROD_W     = 2 * OPND_W;
  localparam int SUM_W      = 36;  // three-term sums before clipping
  localparam int ACC_W      = 35;  // k1 + 2 k2 + 2 k3 + k4
  localparam int MAG_W      = 33;  // magnitudes fed to the divide-by-3 multiply

  // floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT, exact for n < 2^33
  localparam int DIV3_SHIFT = 33;
  localparam logic signed [OPND_W-1:0] DIV3_MUL = 34'sh0AAAAAAAB;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
  } mul_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_MU   = 3'd0,
    REG_GAIN_RCP  = 3'd1,
    REG_TIME_STEP = 3'd2,
    REG_INIT_X    = 3'd3,
    REG_INIT_Y    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_AVG,
    ST_DONE
  } st_e;

  // Sequencer phases. EV_* run once per slope evaluation, AV_* once per step.
  typedef enum logic [4:0] {
    EV_SQ,
    EV_RCP,
    EV_CUBE,
    EV_DY,
    EV_DIV,
    EV_INNER,
    EV_MU,
    EV_KX,
    EV_DX,
    EV_NEXT,
    AV_ABSX,
    AV_MULX,
    AV_QX,
    AV_MULY,
    AV_QY,
    AV_UPDX,
    AV_UPDY
  } ph_e;

  localparam sum_t SUM_MAX = 36'sh07FFFFFFF;
  localparam sum_t SUM_MIN = 36'shF80000000;

  function automatic word_t sat_word(input sum_t v);
    word_t r;
    if (v > SUM_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SUM_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = signed'(v[WORD_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic sat_hit(input sum_t v);
    return (v > SUM_MAX) || (v < SUM_MIN);
  endfunction

endpackage

// ----- rtl/vdp_if.sv -----
// Input and output channel interfaces of the Van der Pol stepper.
`timescale 1ns / 1ps

interface vdp_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface vdp_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [vdp_pkg::WORD_W-1:0] pos_x;
  logic signed [vdp_pkg::WORD_W-1:0] pos_y;
  logic [vdp_pkg::IDX_W-1:0]       step_index;
  logic                            saturated;

  modport source (output valid, output pos_x, output pos_y, output step_index,
                  output saturated, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input step_index,
                  input saturated, output ready);
endinterface

// ----- rtl/vdp_mul_unit.sv -----
// Shared signed multiplier with registered product, fixed-point rounding and clip.
`timescale 1ns / 1ps

module vdp_mul_unit #(
  parameter int FRAC_BITS = vdp_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  vdp_pkg::mul_req_t       req_i,
  output vdp_pkg::word_t          fx_o,   // (a*b) >> FRAC_BITS, round half up, clipped
  output logic [vdp_pkg::WORD_W-1:0] quo_o // raw product >> DIV3_SHIFT
);

  localparam vdp_pkg::prod_t HALF  = vdp_pkg::prod_t'(1) <<< (FRAC_BITS - 1);
  localparam vdp_pkg::prod_t P_MAX = vdp_pkg::prod_t'(32'sh7FFFFFFF);
  localparam vdp_pkg::prod_t P_MIN = -P_MAX - vdp_pkg::prod_t'(1);

  vdp_pkg::opnd_t op_a;
  vdp_pkg::opnd_t op_b;
  vdp_pkg::prod_t prod_q;
  vdp_pkg::prod_t rnd;
  vdp_pkg::prod_t shr;

  assign op_a = req_i.a;
  assign op_b = req_i.b;

  always_ff @(posedge clk_i) begin
    prod_q <= vdp_pkg::prod_t'(op_a) * vdp_pkg::prod_t'(op_b);
  end

  always_comb begin
    rnd = prod_q + HALF;
    shr = rnd >>> FRAC_BITS;
    if (shr > P_MAX) begin
      fx_o = 32'sh7FFFFFFF;
    end else if (shr < P_MIN) begin
      fx_o = 32'sh80000000;
    end else begin
      fx_o = signed'(shr[vdp_pkg::WORD_W-1:0]);
    end
  end

  assign quo_o = prod_q[vdp_pkg::DIV3_SHIFT +: vdp_pkg::WORD_W];

endmodule

// ----- rtl/van_der_pol_rk4_stepper.sv -----
// Van der Pol oscillator stepper: one fixed-step RK4 update per input transaction.
// Sequence: 4 slope evaluations, then averaging/update phases and 1 commit; all products
//   share one multiplier.
// Flow: one transaction per step; ready is low while a step is in flight and
//   the commit stalls while the output register still holds an unread result.
// Reset: registers at defaults, x = 1.0, y = 0, step index 0, output empty.
`timescale 1ns / 1ps

module van_der_pol_rk4_stepper #(
  parameter int FRAC_BITS = vdp_pkg::FRAC_BITS_DEF,
  parameter int STEP_BITS = vdp_pkg::STEP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  vdp_in_if.sink                         in_i,
  vdp_out_if.source                      out_o
);

  localparam int WORD_W = vdp_pkg::WORD_W;
  localparam int SUM_W  = vdp_pkg::SUM_W;
  localparam int ACC_W  = vdp_pkg::ACC_W;
  localparam int MAG_W  = vdp_pkg::MAG_W;
  localparam int OPND_W = vdp_pkg::OPND_W;
  localparam int MU_W   = vdp_pkg::MU_W;
  localparam int DT_W   = vdp_pkg::DT_W;
  localparam int IDX_W  = vdp_pkg::IDX_W;

  // Reset values of the configuration registers, scaled to FRAC_BITS
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [MU_W-1:0] RST_MU  = MU_W'(ONE_FX * 64'd7);
  localparam logic [MU_W-1:0] RST_RCP = MU_W'((ONE_FX + 64'd3) / 64'd7);
  localparam logic [DT_W-1:0] RST_DT  = DT_W'((ONE_FX + 64'd5) / 64'd10);
  localparam vdp_pkg::word_t  RST_X   = signed'(ONE_FX[WORD_W-1:0]);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MU_W-1:0] mu_q, rcp_q;
  logic [DT_W-1:0] dt_q;
  vdp_pkg::word_t  ix_q, iy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q  <= RST_MU;
      rcp_q <= RST_RCP;
      dt_q  <= RST_DT;
      ix_q  <= RST_X;
      iy_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vdp_pkg::REG_GAIN_MU:   mu_q  <= cfg_data_i[MU_W-1:0];
        vdp_pkg::REG_GAIN_RCP:  rcp_q <= cfg_data_i[MU_W-1:0];
        vdp_pkg::REG_TIME_STEP: dt_q  <= cfg_data_i[DT_W-1:0];
        vdp_pkg::REG_INIT_X:    ix_q  <= signed'(cfg_data_i[WORD_W-1:0]);
        vdp_pkg::REG_INIT_Y:    iy_q  <= signed'(cfg_data_i[WORD_W-1:0]);
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State and datapath registers
  // ---------------------------------------------------------------------------
  vdp_pkg::st_e state_q, state_d;
  vdp_pkg::ph_e phase_q, phase_d;
  logic [1:0]   stage_q, stage_d;   // RK4 slope being evaluated: k1..k4

  vdp_pkg::word_t       x_q, x_d, y_q, y_d;       // committed state
  logic [STEP_BITS-1:0] cnt_q, cnt_d;
  vdp_pkg::word_t       xa_q, xa_d, ya_q, ya_d;   // evaluation point, later new state
  vdp_pkg::word_t       yn_q, yn_d;               // next ya, held until inner is done
  vdp_pkg::word_t       kx_q, kx_d, ky_q, ky_d;   // current slopes, later averages
  vdp_pkg::word_t       inner_q, inner_d;
  logic [MAG_W-1:0]     t_q, t_d;                 // x^2, |x^3|, |sum|/2
  logic                 neg_q, neg_d;
  vdp_pkg::acc_t        sx_q, sx_d, sy_q, sy_d;   // weighted slope sums
  logic                 hit_q, hit_d;

  logic                 out_vld_q, out_vld_d;
  vdp_pkg::word_t       out_x_q, out_x_d, out_y_q, out_y_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic                 out_sat_q, out_sat_d;

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  vdp_pkg::mul_req_t mul_req;
  vdp_pkg::word_t    fx;
  logic [WORD_W-1:0] quo;

  vdp_mul_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .fx_o  (fx),
    .quo_o (quo)
  );

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  logic accept, out_free, last_stage, dbl_weight;
  logic [IDX_W-1:0] cnt_idx;

  assign in_i.ready = (state_q == vdp_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign last_stage = (stage_q == 2'd3);
  assign dbl_weight = (stage_q == 2'd1) || (stage_q == 2'd2);

  generate
    if (STEP_BITS >= IDX_W) begin : g_idx_trunc
      assign cnt_idx = cnt_q[IDX_W-1:0];
    end else begin : g_idx_ext
      assign cnt_idx = {{(IDX_W - STEP_BITS){1'b0}}, cnt_q};
    end
  endgenerate

  vdp_pkg::opnd_t   op_xa, op_t, op_h, op_dt, op_mu, op_rcp;
  logic [DT_W-1:0]  hstep;
  logic signed [OPND_W-1:0] q_s, q_sgn;
  logic signed [WORD_W:0]   fx_w, fx_mag;
  vdp_pkg::acc_t    fx_acc, fx_wgt, acc_src, acc_mag;
  vdp_pkg::sum_t    upd_x, upd_y, inner_sum;

  // k1, k2 step to the half point, k3 to the full point
  assign hstep  = (stage_q == 2'd2) ? dt_q : (dt_q >> 1);
  assign op_xa  = OPND_W'(xa_q);
  assign op_t   = signed'({1'b0, t_q});
  assign op_h   = signed'({{(OPND_W - DT_W){1'b0}}, hstep});
  assign op_dt  = signed'({{(OPND_W - DT_W){1'b0}}, dt_q});
  assign op_mu  = signed'({{(OPND_W - MU_W){1'b0}}, mu_q});
  assign op_rcp = signed'({{(OPND_W - MU_W){1'b0}}, rcp_q});

  // quotient by 3 with the sign put back: truncation toward zero
  assign q_s    = signed'({{(OPND_W - WORD_W){1'b0}}, quo});
  assign q_sgn  = neg_q ? -q_s : q_s;

  assign fx_w   = (WORD_W + 1)'(fx);
  assign fx_mag = fx[WORD_W-1] ? -fx_w : fx_w;
  assign fx_acc = ACC_W'(fx);
  assign fx_wgt = dbl_weight ? (fx_acc <<< 1) : fx_acc;

  assign acc_src = (phase_q == vdp_pkg::AV_ABSX) ? sx_q : sy_q;
  assign acc_mag = acc_src[ACC_W-1] ? -acc_src : acc_src;

  assign upd_x     = SUM_W'(x_q) + SUM_W'(fx);
  assign upd_y     = SUM_W'(y_q) + SUM_W'(fx);
  assign inner_sum = SUM_W'(xa_q) - SUM_W'(q_sgn) - SUM_W'(ya_q);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    stage_d = stage_q;
    unique case (state_q)
      vdp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = vdp_pkg::ST_EVAL;
          phase_d = vdp_pkg::EV_SQ;
          stage_d = 2'd0;
        end
      end
      vdp_pkg::ST_EVAL: begin
        unique case (phase_q)
          vdp_pkg::EV_SQ:    phase_d = vdp_pkg::EV_RCP;
          vdp_pkg::EV_RCP:   phase_d = vdp_pkg::EV_CUBE;
          vdp_pkg::EV_CUBE:  phase_d = vdp_pkg::EV_DY;
          vdp_pkg::EV_DY:    phase_d = vdp_pkg::EV_DIV;
          vdp_pkg::EV_DIV:   phase_d = vdp_pkg::EV_INNER;
          vdp_pkg::EV_INNER: phase_d = vdp_pkg::EV_MU;
          vdp_pkg::EV_MU:    phase_d = vdp_pkg::EV_KX;
          vdp_pkg::EV_KX:    phase_d = vdp_pkg::EV_DX;
          vdp_pkg::EV_DX:    phase_d = vdp_pkg::EV_NEXT;
          vdp_pkg::EV_NEXT: begin
            if (last_stage) begin
              state_d = vdp_pkg::ST_AVG;
              phase_d = vdp_pkg::AV_ABSX;
            end else begin
              stage_d = stage_q + 2'd1;
              phase_d = vdp_pkg::EV_SQ;
            end
          end
          default:           phase_d = vdp_pkg::EV_SQ;
        endcase
      end
      vdp_pkg::ST_AVG: begin
        unique case (phase_q)
          vdp_pkg::AV_ABSX: phase_d = vdp_pkg::AV_MULX;
          vdp_pkg::AV_MULX: phase_d = vdp_pkg::AV_QX;
          vdp_pkg::AV_QX:   phase_d = vdp_pkg::AV_MULY;
          vdp_pkg::AV_MULY: phase_d = vdp_pkg::AV_QY;
          vdp_pkg::AV_QY:   phase_d = vdp_pkg::AV_UPDX;
          vdp_pkg::AV_UPDX: phase_d = vdp_pkg::AV_UPDY;
          vdp_pkg::AV_UPDY: state_d = vdp_pkg::ST_DONE;
          default:          phase_d = vdp_pkg::AV_ABSX;
        endcase
      end
      vdp_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = vdp_pkg::ST_IDLE;
        end
      end
      default: state_d = vdp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath control. Most phases write back the product issued
  // in the previous phase and/or issue a new one.
  // ---------------------------------------------------------------------------
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    cnt_d     = cnt_q;
    xa_d      = xa_q;
    ya_d      = ya_q;
    yn_d      = yn_q;
    kx_d      = kx_q;
    ky_d      = ky_q;
    inner_d   = inner_q;
    t_d       = t_q;
    neg_d     = neg_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    hit_d     = hit_q;
    mul_req   = '0;
    out_vld_d = out_vld_q && !out_o.ready;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;
    out_idx_d = out_idx_q;
    out_sat_d = out_sat_q;

    unique case (state_q)
      vdp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.restart) begin
            x_d   = ix_q;
            y_d   = iy_q;
            cnt_d = '0;
          end
          xa_d  = in_i.restart ? ix_q : x_q;
          ya_d  = in_i.restart ? iy_q : y_q;
          sx_d  = '0;
          sy_d  = '0;
          hit_d = 1'b0;
        end
      end
      vdp_pkg::ST_EVAL: begin
        unique case (phase_q)
          vdp_pkg::EV_SQ: begin
            mul_req = '{a: op_xa, b: op_xa};
          end
          vdp_pkg::EV_RCP: begin
            t_d     = {1'b0, fx};  // x^2 is never negative
            mul_req = '{a: op_xa, b: op_rcp};
          end
          vdp_pkg::EV_CUBE: begin
            ky_d    = fx;
            sy_d    = sy_q + fx_wgt;
            mul_req = '{a: op_t, b: op_xa};
          end
          vdp_pkg::EV_DY: begin
            t_d     = unsigned'(fx_mag);
            neg_d   = fx[WORD_W-1];
            mul_req = '{a: op_h, b: OPND_W'(ky_q)};
          end
          vdp_pkg::EV_DIV: begin
            yn_d    = vdp_pkg::sat_word(upd_y);
            mul_req = '{a: op_t, b: vdp_pkg::DIV3_MUL};
          end
          vdp_pkg::EV_INNER: begin
            inner_d = vdp_pkg::sat_word(inner_sum);
          end
          vdp_pkg::EV_MU: begin
            mul_req = '{a: op_mu, b: OPND_W'(inner_q)};
          end
          vdp_pkg::EV_KX: begin
            kx_d = fx;
            sx_d = sx_q + fx_wgt;
          end
          vdp_pkg::EV_DX: begin
            mul_req = '{a: op_h, b: OPND_W'(kx_q)};
          end
          vdp_pkg::EV_NEXT: begin
            xa_d = vdp_pkg::sat_word(upd_x);
            ya_d = yn_q;
          end
          default: ;
        endcase
      end
      vdp_pkg::ST_AVG: begin
        unique case (phase_q)
          vdp_pkg::AV_ABSX: begin
            t_d   = MAG_W'(unsigned'(acc_mag) >> 1);
            neg_d = sx_q[ACC_W-1];
          end
          vdp_pkg::AV_MULX: begin
            mul_req = '{a: op_t, b: vdp_pkg::DIV3_MUL};
          end
          vdp_pkg::AV_QX: begin
            kx_d  = signed'(q_sgn[WORD_W-1:0]);
            t_d   = MAG_W'(unsigned'(acc_mag) >> 1);
            neg_d = sy_q[ACC_W-1];
          end
          vdp_pkg::AV_MULY: begin
            mul_req = '{a: op_t, b: vdp_pkg::DIV3_MUL};
          end
          vdp_pkg::AV_QY: begin
            ky_d    = signed'(q_sgn[WORD_W-1:0]);
            mul_req = '{a: op_dt, b: OPND_W'(kx_q)};
          end
          vdp_pkg::AV_UPDX: begin
            xa_d    = vdp_pkg::sat_word(upd_x);
            hit_d   = hit_q || vdp_pkg::sat_hit(upd_x);
            mul_req = '{a: op_dt, b: OPND_W'(ky_q)};
          end
          vdp_pkg::AV_UPDY: begin
            ya_d  = vdp_pkg::sat_word(upd_y);
            hit_d = hit_q || vdp_pkg::sat_hit(upd_y);
          end
          default: ;
        endcase
      end
      vdp_pkg::ST_DONE: begin
        // report the pre-step state, then commit the new one
        if (out_free) begin
          out_vld_d = 1'b1;
          out_x_d   = x_q;
          out_y_d   = y_q;
          out_idx_d = cnt_idx;
          out_sat_d = hit_q;
          x_d       = xa_q;
          y_d       = ya_q;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vdp_pkg::ST_IDLE;
      phase_q   <= vdp_pkg::EV_SQ;
      stage_q   <= '0;
      x_q       <= RST_X;
      y_q       <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      x_q       <= x_d;
      y_q       <= y_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q      <= xa_d;
    ya_q      <= ya_d;
    yn_q      <= yn_d;
    kx_q      <= kx_d;
    ky_q      <= ky_d;
    inner_q   <= inner_d;
    t_q       <= t_d;
    neg_q     <= neg_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    hit_q     <= hit_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    out_idx_q <= out_idx_d;
    out_sat_q <= out_sat_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.pos_x      = out_x_q;
  assign out_o.pos_y      = out_y_q;
  assign out_o.step_index = out_idx_q;
  assign out_o.saturated  = out_sat_q;

endmodule

// ----- dv/van_der_pol_rk4_stepper_tb.sv -----
// Self-checking testbench for the Van der Pol RK4 stepper: directed table, random phases.
`timescale 1ns / 1ps

module van_der_pol_rk4_stepper_tb;
  import vdp_pkg::*;

  // Q8.24 helpers for the trajectory predictor
  localparam int     FRAC    = FRAC_BITS_DEF;
  localparam int     ONE_I   = 1 << FRAC;
  localparam longint Q_ONE   = longint'(1) << FRAC;
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;

  // Register data patterns used by the directed table and the corner profile
  localparam logic [CFG_DATA_W-1:0] DATA_ONE = 32'h0100_0000;
  localparam logic [CFG_DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] DATA_MIN = 32'h8000_0000;
  localparam logic [CFG_DATA_W-1:0] DATA_ALL = 32'hFFFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] MU_RST   = 32'h0700_0000;  // 7.0
  localparam logic [CFG_DATA_W-1:0] RCP_RST  = 32'd2396745;    // 1/7
  localparam logic [CFG_DATA_W-1:0] DT_RST   = 32'd1677722;    // 0.1
  localparam logic [CFG_DATA_W-1:0] DT_TOP   = 32'h01FF_FFFF;  // all dt bits set

  // Indexes the block does not decode; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int RANDOM_TICKS = 700;
  localparam int DRAIN_CYCLES = 60;       // a bit over the stepper's latency
  localparam int TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    word_t            x;
    word_t            y;
    logic [IDX_W-1:0] idx;
    logic             sat;
  } osc_point_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    bit                    known;   // want holds a hand-written expectation
    osc_point_t            want;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  vdp_in_if  tick_ch ();
  vdp_out_if point_ch ();

  van_der_pol_rk4_stepper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_ch),
    .out_o      (point_ch)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the register file and the trajectory state
  logic [MU_W-1:0]  mu_q;
  logic [MU_W-1:0]  mu_inv_q;
  logic [DT_W-1:0]  dt_q;
  word_t            x_start;
  word_t            y_start;
  word_t            traj_x;
  word_t            traj_y;
  logic [IDX_W-1:0] traj_step;

  osc_point_t  due_points[$];   // expected points, oldest first
  script_row_t script[$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int          ticks_sent   = 0;
  bit          tx_calm;
  bit          rx_calm;

  // ---------------------------------------------------------------------------
  // Trajectory predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  function automatic bit out_of_word(input longint v);
    return (v > WORD_HI) || (v < WORD_LO);
  endfunction

  // Q8.24 product: exact, round half toward +inf, then clamp
  function automatic longint qmul(input longint a, input longint b);
    longint r;
    r = a * b + (longint'(1) << (FRAC - 1));
    return clamp32(r >>> FRAC);
  endfunction

  // dx = mu * (x - x^3/3 - y); the /3 truncates toward zero
  function automatic longint x_rate(input longint x, input longint y);
    longint cube;
    cube = qmul(qmul(x, x), x);
    return qmul(longint'(mu_q), clamp32(x - cube / 3 - y));
  endfunction

  function automatic longint y_rate(input longint x);
    return qmul(x, longint'(mu_inv_q));
  endfunction

  // One tick: report the current point, then take a full RK4 step.
  // Only the final update may raise the saturation flag.
  function automatic osc_point_t rk4_tick(input logic restart);
    osc_point_t p;
    longint x, y, dt, hdt, xa, ya;
    longint k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y;
    longint nx, ny;
    if (restart) begin
      traj_x    = x_start;
      traj_y    = y_start;
      traj_step = '0;
    end
    x   = traj_x;
    y   = traj_y;
    dt  = longint'(dt_q);
    hdt = dt >>> 1;

    k1x = x_rate(x, y);
    k1y = y_rate(x);
    xa  = clamp32(x + qmul(hdt, k1x));
    ya  = clamp32(y + qmul(hdt, k1y));
    k2x = x_rate(xa, ya);
    k2y = y_rate(xa);
    xa  = clamp32(x + qmul(hdt, k2x));
    ya  = clamp32(y + qmul(hdt, k2y));
    k3x = x_rate(xa, ya);
    k3y = y_rate(xa);
    xa  = clamp32(x + qmul(dt, k3x));
    ya  = clamp32(y + qmul(dt, k3y));
    k4x = x_rate(xa, ya);
    k4y = y_rate(xa);

    nx = x + qmul(dt, (k1x + 2 * k2x + 2 * k3x + k4x) / 6);
    ny = y + qmul(dt, (k1y + 2 * k2y + 2 * k3y + k4y) / 6);

    p.x   = traj_x;
    p.y   = traj_y;
    p.idx = traj_step;
    p.sat = out_of_word(nx) || out_of_word(ny);

    traj_x    = word_t'(clamp32(nx));
    traj_y    = word_t'(clamp32(ny));
    traj_step = traj_step + 1'b1;   // wraps at the index width
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_point();
    osc_point_t got;
    osc_point_t want;
    got.x   = point_ch.pos_x;
    got.y   = point_ch.pos_y;
    got.idx = point_ch.step_index;
    got.sat = point_ch.saturated;
    results_seen++;
    if (due_points.size() == 0) begin
      note_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      return;
    end
    want = due_points.pop_front();
    if (got.x !== want.x)
      note_mismatch($sformatf("result %0d pos_x got %h want %h", results_seen, got.x, want.x));
    if (got.y !== want.y)
      note_mismatch($sformatf("result %0d pos_y got %h want %h", results_seen, got.y, want.y));
    if (got.idx !== want.idx)
      note_mismatch($sformatf("result %0d step_index got %0d want %0d", results_seen,
                              got.idx, want.idx));
    if (got.sat !== want.sat)
      note_mismatch($sformatf("result %0d saturated got %b want %b", results_seen,
                              got.sat, want.sat));
  endtask

  // Outputs are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && point_ch.valid === 1'b1 && point_ch.ready === 1'b1) check_point();
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; everything is driven on the falling edge
  // ---------------------------------------------------------------------------

  task automatic drain();
    while (due_points.size() != 0) @(negedge clk_i);
  endtask

  // Register writes only land while the block is idle: input held off and
  // every outstanding point collected (every tick yields exactly one point).
  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    tick_ch.valid <= 1'b0;
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (addr)
      REG_GAIN_MU:   mu_q     = data[MU_W-1:0];
      REG_GAIN_RCP:  mu_inv_q = data[MU_W-1:0];
      REG_TIME_STEP: dt_q     = data[DT_W-1:0];
      REG_INIT_X:    x_start  = word_t'(data);
      REG_INIT_Y:    y_start  = word_t'(data);
      default: ;     // undecoded index, no effect
    endcase
    @(negedge clk_i);
  endtask

  // Mostly back-to-back or short gaps, occasionally long, with calm stretches
  function automatic int tx_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return $urandom_range(61, 120);
  endfunction

  task automatic send_tick(input logic rs, input bit known, input osc_point_t want);
    int         gap;
    osc_point_t guess;
    cfg_we_i <= 1'b0;
    gap = tx_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= rs;
    do @(posedge clk_i); while (tick_ch.ready !== 1'b1);
    // Expectation goes in after the transaction edge, so a point that shows up
    // in the same cycle as its own tick is flagged rather than raced.
    @(negedge clk_i);
    guess = rk4_tick(rs);
    due_points.push_back(known ? want : guess);
    ticks_sent++;
    if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
  endtask

  function automatic void add_write(input logic [CFG_IDX_W-1:0] a,
                                    input logic [CFG_DATA_W-1:0] d);
    script_row_t r;
    r.kind    = ROW_WRITE;
    r.addr    = a;
    r.data    = d;
    r.restart = 1'b0;
    r.known   = 1'b0;
    r.want    = '0;
    script.push_back(r);
  endfunction

  function automatic void add_tick(input logic rs);
    script_row_t r;
    r.kind    = ROW_TICK;
    r.addr    = '0;
    r.data    = '0;
    r.restart = rs;
    r.known   = 1'b0;
    r.want    = '0;
    script.push_back(r);
  endfunction

  function automatic void add_known(input logic rs, input word_t x, input word_t y,
                                    input logic [IDX_W-1:0] n, input logic s);
    script_row_t r;
    r.kind      = ROW_TICK;
    r.addr      = '0;
    r.data      = '0;
    r.restart   = rs;
    r.known     = 1'b1;
    r.want.x    = x;
    r.want.y    = y;
    r.want.idx  = n;
    r.want.sat  = s;
    script.push_back(r);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] edge_word();
    case ($urandom_range(0, 4))
      0:       return DATA_MIN;
      1:       return DATA_MAX;
      2:       return '0;
      3:       return DATA_ALL;   // -1 lsb
      default: return DATA_ONE;
    endcase
  endfunction

  // New register setting for a random phase. Three profiles:
  //   tame   - oscillator-like values, matching 1/mu most of the time
  //   wild   - raw random words, top bits beyond each register included
  //   corner - zero, one lsb, minus one lsb, 1.0 and full-scale values
  task automatic shuffle_setup();
    int                    kind;
    longint                m;
    logic [CFG_DATA_W-1:0] mu_v, rcp_v, dt_v, x_v, y_v;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      m     = $urandom_range(ONE_I / 20, 12 * ONE_I);
      mu_v  = 32'(m);
      rcp_v = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(1, 2 * ONE_I))
                                          : 32'((Q_ONE * Q_ONE) / m);
      dt_v  = $urandom_range(ONE_I / 1000, ONE_I / 4);
      x_v   = $urandom_range(0, 8 * ONE_I) - 4 * ONE_I;
      y_v   = $urandom_range(0, 8 * ONE_I) - 4 * ONE_I;
    end else if (kind < 85) begin
      mu_v  = $urandom();
      rcp_v = $urandom();
      dt_v  = $urandom();
      x_v   = $urandom();
      y_v   = $urandom();
    end else begin
      case ($urandom_range(0, 2))
        0:       mu_v = '0;
        1:       mu_v = 32'd1;
        default: mu_v = DATA_MAX;
      endcase
      case ($urandom_range(0, 2))
        0:       rcp_v = '0;
        1:       rcp_v = 32'd1;
        default: rcp_v = DATA_MAX;
      endcase
      case ($urandom_range(0, 3))
        0:       dt_v = '0;
        1:       dt_v = 32'd1;
        2:       dt_v = DATA_ONE;
        default: dt_v = DT_TOP;
      endcase
      x_v = edge_word();
      y_v = edge_word();
    end
    // Leave a register untouched now and then so settings mix across phases
    if ($urandom_range(0, 5) != 0) write_reg(REG_GAIN_MU, mu_v);
    if ($urandom_range(0, 5) != 0) write_reg(REG_GAIN_RCP, rcp_v);
    if ($urandom_range(0, 5) != 0) write_reg(REG_TIME_STEP, dt_v);
    if ($urandom_range(0, 5) != 0) write_reg(REG_INIT_X, x_v);
    if ($urandom_range(0, 5) != 0) write_reg(REG_INIT_Y, y_v);
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_LO, $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready stalls, mostly short, a few long, with calm stretches
  // ---------------------------------------------------------------------------

  initial begin : rx_side
    int stall;
    int r;
    stall          = 0;
    rx_calm        = 1'b0;
    point_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && !rx_calm) begin
        r = $urandom_range(0, 99);
        if (r < 10)      stall = $urandom_range(1, 3);
        else if (r < 13) stall = $urandom_range(4, 40);
        else if (r < 14) stall = $urandom_range(41, 150);
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        point_ch.ready <= 1'b0;
        stall--;
      end else begin
        point_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int target;
    int burst;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    tx_calm         = 1'b0;

    // Reset values of the register mirror and the trajectory
    mu_q      = MU_RST[MU_W-1:0];
    mu_inv_q  = RCP_RST[MU_W-1:0];
    dt_q      = DT_RST[DT_W-1:0];
    x_start   = word_t'(DATA_ONE);
    y_start   = '0;
    traj_x    = word_t'(DATA_ONE);
    traj_y    = '0;
    traj_step = '0;

    // Directed table. Rows with a typed expectation are the obvious ones:
    // state right after reset or restart, and steps that cannot move the state.
    add_known(1'b0, DATA_ONE, '0, 20'd0, 1'b0);        // reset state, no restart
    add_tick(1'b0);
    add_tick(1'b0);
    add_known(1'b1, DATA_ONE, '0, 20'd0, 1'b0);        // restart after steps
    add_tick(1'b0);
    // Full-scale start: x^3 and the x slopes clip, the final update clips too
    add_write(REG_INIT_X, DATA_MAX);
    add_write(REG_INIT_Y, DATA_MIN);
    add_known(1'b1, DATA_MAX, DATA_MIN, 20'd0, 1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    // Zero dt freezes the state; only the index moves
    add_write(REG_TIME_STEP, '0);
    add_known(1'b1, DATA_MAX, DATA_MIN, 20'd0, 1'b0);
    add_known(1'b0, DATA_MAX, DATA_MIN, 20'd1, 1'b0);
    add_write(REG_INIT_X, DATA_MIN);
    add_write(REG_INIT_Y, DATA_MAX);
    add_known(1'b1, DATA_MIN, DATA_MAX, 20'd0, 1'b0);
    // Largest mu, 1/mu and dt; mu written with its unused top bit set
    add_write(REG_TIME_STEP, DT_TOP);
    add_write(REG_GAIN_MU, DATA_ALL);
    add_write(REG_GAIN_RCP, DATA_MAX);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    // Zero mu and zero 1/mu: both slopes vanish, state holds at dt = 1.0
    add_write(REG_GAIN_MU, '0);
    add_write(REG_GAIN_RCP, '0);
    add_write(REG_TIME_STEP, DATA_ONE);
    add_known(1'b1, DATA_MIN, DATA_MAX, 20'd0, 1'b0);
    add_known(1'b0, DATA_MIN, DATA_MAX, 20'd1, 1'b0);
    // Undecoded indexes must not disturb the zero gains
    add_write(REG_SPARE_LO, DATA_ALL);
    add_write(REG_SPARE_HI, DATA_MAX);
    add_known(1'b0, DATA_MIN, DATA_MAX, 20'd2, 1'b0);
    // One-lsb gains and dt
    add_write(REG_GAIN_MU, 32'd1);
    add_write(REG_GAIN_RCP, 32'd1);
    add_write(REG_TIME_STEP, 32'd1);
    add_write(REG_INIT_X, DATA_ONE);
    add_write(REG_INIT_Y, '0);
    add_known(1'b1, DATA_ONE, '0, 20'd0, 1'b0);
    add_tick(1'b0);
    // Back to the default oscillator
    add_write(REG_GAIN_MU, MU_RST);
    add_write(REG_GAIN_RCP, RCP_RST);
    add_write(REG_TIME_STEP, DT_RST);
    add_known(1'b1, DATA_ONE, '0, 20'd0, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].addr, script[i].data);
      end else begin
        send_tick(script[i].restart, script[i].known, script[i].want);
      end
    end

    // Random phases: new setting, then a run of ticks. Most runs open with a
    // restart; some carry the old trajectory into the new parameters.
    target = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < target) begin
      shuffle_setup();
      burst = $urandom_range(5, 45);
      for (int n = 0; n < burst; n++) begin
        send_tick((n == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 29) == 0),
                  1'b0, '0);
      end
    end

    tick_ch.valid <= 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, sized for several times the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
